[hdl/plc_pkg.sv]
// Shared types and codes for the positional list block.
// No dependencies; used by plc_cell and positional_list_insert_delete_find.
`timescale 1ns / 1ps

package plc_pkg;

    localparam int VALUE_W  = 31;
    localparam int ACTION_W = 2;
    localparam int POS_W    = 9;
    localparam int STATUS_W = 2;
    localparam int FOUND_W  = 10;
    localparam int LEN_W    = 9;
    localparam int LANES    = 16;  // match bits examined per scan cycle

    localparam logic [ACTION_W-1:0] ACT_APPEND = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_DELETE = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_FIND   = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

    localparam logic [FOUND_W-1:0] FOUND_NONE = 10'h3FF;  // -1

    // operation broadcast to every cell
    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_DELETE = 2'd2,
        CELL_MATCH  = 2'd3
    } cell_op_t;

    typedef struct packed {
        cell_op_t             op;
        logic [VALUE_W-1:0]   value;
    } cell_cmd_t;

endpackage

[hdl/plc_cell.sv]
// One list slot: holds an entry and its match flag, trades with its neighbours.
// Depends on plc_pkg.
`timescale 1ns / 1ps

module plc_cell #(
    parameter int IDX = 0,
    parameter int CW  = 9
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  plc_pkg::cell_cmd_t         cmd,
    input  logic [CW-1:0]              pos_idx,    // 0-based target slot
    input  logic [CW-1:0]              count,
    input  logic [plc_pkg::VALUE_W-1:0] left_entry,
    input  logic [plc_pkg::VALUE_W-1:0] right_entry,
    output logic [plc_pkg::VALUE_W-1:0] entry,
    output logic                       match
);

    localparam logic [CW-1:0] MY_IDX = CW'(IDX);

    logic [plc_pkg::VALUE_W-1:0] entry_reg;
    logic [plc_pkg::VALUE_W-1:0] entry_next;
    logic                        match_reg;
    logic                        match_next;

    always_comb begin
        entry_next = entry_reg;
        match_next = match_reg;
        case (cmd.op)
            plc_pkg::CELL_INSERT: begin
                if (MY_IDX == pos_idx) begin
                    entry_next = cmd.value;
                end else if (MY_IDX > pos_idx) begin
                    entry_next = left_entry;
                end
            end
            plc_pkg::CELL_DELETE: begin
                if (MY_IDX >= pos_idx) begin
                    entry_next = right_entry;
                end
            end
            plc_pkg::CELL_MATCH: begin
                match_next = (MY_IDX < count) && (entry_reg == cmd.value);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            match_reg <= 1'b0;
        end else begin
            match_reg <= match_next;
        end
    end

    assign entry = entry_reg;
    assign match = match_reg;

endmodule

[hdl/positional_list_insert_delete_find.sv]
// Top level of the positional list: command decode, row of plc_cell slots,
// first-match scan and output register. Depends on plc_pkg and plc_cell.
`timescale 1ns / 1ps

// Usage
//   s_ channel: one operation per item (append, insert, delete, find).
//   m_ channel: one result per item: status, found position, list length.
//   Append, insert and delete: the row of cells shifts in the accept cycle,
//   result valid on m_ the next cycle; one item per cycle when m_ is free.
//   Find: every cell compares in the accept cycle, then the match flags are
//   scanned 16 slots a cycle from the head until the first set flag or the
//   last group; the result then goes to the output register. No new item
//   is taken while a scan runs.
//   Rejected operations (full list, position out of range) leave the list
//   unchanged and report their status.
//   Reset empties the list at once (length zero); entries need no clearing.
//   When m_tready is low the result holds in the output register and s_
//   stalls until it is taken; a finished scan waits likewise.
module positional_list_insert_delete_find #(
    parameter int CAPACITY = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // action[1:0], position[10:2], value[41:11], zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // status[1:0], found_position[11:2],
                                   // list_length[20:12], zero pad
);

    localparam int CW     = $clog2(CAPACITY + 1);
    localparam int PW     = ((CW > plc_pkg::POS_W) ? CW : plc_pkg::POS_W) + 1;
    localparam int NGROUP = (CAPACITY + plc_pkg::LANES - 1) / plc_pkg::LANES;
    localparam int GW     = (NGROUP > 1) ? $clog2(NGROUP) : 1;
    localparam int PADW   = NGROUP * plc_pkg::LANES;
    localparam int LW     = $clog2(plc_pkg::LANES);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } state_t;

    // input fields
    logic [plc_pkg::ACTION_W-1:0] in_action;
    logic [plc_pkg::POS_W-1:0]    in_position;
    logic [plc_pkg::VALUE_W-1:0]  in_value;

    assign in_action   = s_tdata[1:0];
    assign in_position = s_tdata[10:2];
    assign in_value    = s_tdata[41:11];

    state_t          state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [GW-1:0]   grp_reg, grp_next;
    logic            m_valid_reg, m_valid_next;
    logic [23:0]     m_data_reg, m_data_next;

    logic                s_accept;
    logic                out_free;
    logic                list_full;
    logic [PW-1:0]       pos_w;
    logic [PW-1:0]       cnt_w;
    logic [PW-1:0]       cnt_next_w;
    plc_pkg::cell_cmd_t  cmd;
    logic [CW-1:0]       pos_idx;
    logic [plc_pkg::STATUS_W-1:0] status;

    // scan
    logic [PADW-1:0]            match_pad;
    logic [plc_pkg::LANES-1:0]  grp_bits;
    logic                       grp_hit;
    logic [LW-1:0]              hit_lane;
    logic [PW-1:0]              hit_pos;
    logic                       last_grp;

    // row of cells
    logic [plc_pkg::VALUE_W-1:0] entry [CAPACITY];
    logic [CAPACITY-1:0]         match_vec;

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [plc_pkg::VALUE_W-1:0] left_e;
        logic [plc_pkg::VALUE_W-1:0] right_e;
        if (i == 0) begin : g_head
            assign left_e = in_value;
        end else begin : g_mid_l
            assign left_e = entry[i-1];
        end
        if (i == CAPACITY - 1) begin : g_tail
            assign right_e = entry[i];
        end else begin : g_mid_r
            assign right_e = entry[i+1];
        end
        plc_cell #(
            .IDX (i),
            .CW  (CW)
        ) u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .cmd         (cmd),
            .pos_idx     (pos_idx),
            .count       (count_reg),
            .left_entry  (left_e),
            .right_entry (right_e),
            .entry       (entry[i]),
            .match       (match_vec[i])
        );
    end

    if (PADW > CAPACITY) begin : g_pad
        assign match_pad = {{(PADW - CAPACITY){1'b0}}, match_vec};
    end else begin : g_nopad
        assign match_pad = match_vec;
    end

    assign out_free  = !m_valid_reg || m_tready;
    assign s_tready  = (state_reg == ST_IDLE) && out_free;
    assign s_accept  = s_tvalid && s_tready;
    assign list_full = (count_reg == CW'(CAPACITY));
    assign pos_w     = PW'(in_position);
    assign cnt_w     = PW'(count_reg);

    // decode: what the cells do and how the length moves
    always_comb begin
        cmd.op     = plc_pkg::CELL_HOLD;
        cmd.value  = in_value;
        pos_idx    = count_reg;
        cnt_next_w = cnt_w;
        status     = plc_pkg::ST_OK;
        if (s_accept) begin
            unique case (in_action)
                plc_pkg::ACT_APPEND: begin
                    if (list_full) begin
                        status = plc_pkg::ST_FULL;
                    end else begin
                        cmd.op     = plc_pkg::CELL_INSERT;
                        cnt_next_w = cnt_w + PW'(1);
                    end
                end
                plc_pkg::ACT_INSERT: begin
                    if (list_full) begin
                        status = plc_pkg::ST_FULL;
                    end else if (pos_w == '0 || pos_w > cnt_w + PW'(1)) begin
                        status = plc_pkg::ST_RANGE;
                    end else begin
                        cmd.op     = plc_pkg::CELL_INSERT;
                        pos_idx    = CW'(pos_w - PW'(1));
                        cnt_next_w = cnt_w + PW'(1);
                    end
                end
                plc_pkg::ACT_DELETE: begin
                    if (pos_w == '0 || pos_w > cnt_w) begin
                        status = plc_pkg::ST_RANGE;
                    end else begin
                        cmd.op     = plc_pkg::CELL_DELETE;
                        pos_idx    = CW'(pos_w - PW'(1));
                        cnt_next_w = cnt_w - PW'(1);
                    end
                end
                plc_pkg::ACT_FIND: begin
                    cmd.op = plc_pkg::CELL_MATCH;
                end
                default: begin
                end
            endcase
        end
    end

    // first set flag in the current group of 16
    assign grp_bits = match_pad[grp_reg * plc_pkg::LANES +: plc_pkg::LANES];

    always_comb begin
        grp_hit  = 1'b0;
        hit_lane = '0;
        for (int k = plc_pkg::LANES - 1; k >= 0; k--) begin
            if (grp_bits[k]) begin
                grp_hit  = 1'b1;
                hit_lane = LW'(k);
            end
        end
    end

    assign hit_pos  = PW'({grp_reg, hit_lane}) + PW'(1);
    assign last_grp = (grp_reg == GW'(NGROUP - 1));

    always_comb begin
        state_next   = state_reg;
        count_next   = CW'(cnt_next_w);
        grp_next     = grp_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    if (in_action == plc_pkg::ACT_FIND) begin
                        state_next = ST_SCAN;
                        grp_next   = '0;
                    end else begin
                        m_valid_next = 1'b1;
                        m_data_next  = {3'b000, cnt_next_w[plc_pkg::LEN_W-1:0],
                                        plc_pkg::FOUND_NONE, status};
                    end
                end
            end
            ST_SCAN: begin
                if (grp_hit || last_grp) begin
                    if (out_free) begin
                        state_next   = ST_IDLE;
                        m_valid_next = 1'b1;
                        m_data_next  = {3'b000, cnt_w[plc_pkg::LEN_W-1:0],
                                        grp_hit ? hit_pos[plc_pkg::FOUND_W-1:0]
                                                : plc_pkg::FOUND_NONE,
                                        plc_pkg::ST_OK};
                    end
                end else begin
                    grp_next = grp_reg + GW'(1);
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            grp_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            grp_reg     <= grp_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // checks
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(CAPACITY))
        else $error("list length beyond capacity");

    a_find_scans: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && in_action == plc_pkg::ACT_FIND) |=> (state_reg == ST_SCAN))
        else $error("find did not start a scan");

    a_edit_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && in_action != plc_pkg::ACT_FIND) |=> m_tvalid)
        else $error("edit gave no result");

    a_scan_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |=> $stable(count_reg))
        else $error("length moved during scan");

endmodule

[tb/positional_list_insert_delete_find_tb.sv]
// Self-checking testbench for positional_list_insert_delete_find.
// Drives list operations, predicts each result and compares it on m_.
// Depends on plc_pkg and the RTL of the block; reads no files.
`timescale 1ns / 1ps

module positional_list_insert_delete_find_tb;

    localparam int CAPACITY     = 256;
    localparam int CYCLE_LIMIT  = 200000;  // many times the slowest correct run
    localparam int DRAIN_CYCLES = 40;      // longer than the slowest find scan
    localparam int PHASE_ITEMS  = 160;     // accepted items per idling phase
    localparam int MAX_REPORTS  = 10;

    // one operation as it travels on s_tdata
    typedef struct packed {
        logic [plc_pkg::VALUE_W-1:0]  value;
        logic [plc_pkg::POS_W-1:0]    position;
        logic [plc_pkg::ACTION_W-1:0] action;
    } list_op_t;

    // one reply as it travels on m_tdata
    typedef struct packed {
        logic [plc_pkg::LEN_W-1:0]    length;
        logic [plc_pkg::FOUND_W-1:0]  found;
        logic [plc_pkg::STATUS_W-1:0] status;
    } list_reply_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;

    // items waiting to be driven, replies waiting to arrive
    list_op_t                    pending_ops[$];
    list_reply_t                 expected_replies[$];
    // the list as the block should hold it after every accepted item
    logic [plc_pkg::VALUE_W-1:0] model_list[$];

    logic s_fire = 1'b0;     // item taken at the last rising edge
    int   items_taken = 0;
    int   error_count = 0;
    int   reports     = 0;
    int   cycle_count = 0;
    int   send_idle_pct;
    int   recv_idle_pct;

    // a few fixed values so that find meets duplicates and the edge patterns
    logic [plc_pkg::VALUE_W-1:0] value_pool[4] =
        '{31'h0, 31'h7FFF_FFFF, 31'h4000_0000, 31'd777};

    positional_list_insert_delete_find #(
        .CAPACITY (CAPACITY)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // ---------------------------------------------------------------
    // Prediction: apply one operation to the list copy, return the reply.
    // Full is checked before the position; find takes the first match.
    // ---------------------------------------------------------------
    function automatic list_reply_t predict_list_op(list_op_t op);
        list_reply_t reply;
        int          len;
        int          pos;
        reply.status = plc_pkg::ST_OK;
        reply.found  = plc_pkg::FOUND_NONE;
        len = model_list.size();
        pos = int'(op.position);
        case (op.action)
            plc_pkg::ACT_APPEND: begin
                if (len >= CAPACITY) reply.status = plc_pkg::ST_FULL;
                else model_list.insert(len, op.value);
            end
            plc_pkg::ACT_INSERT: begin
                if (len >= CAPACITY) reply.status = plc_pkg::ST_FULL;
                else if (pos < 1 || pos > len + 1) reply.status = plc_pkg::ST_RANGE;
                else model_list.insert(pos - 1, op.value);
            end
            plc_pkg::ACT_DELETE: begin
                if (pos < 1 || pos > len) reply.status = plc_pkg::ST_RANGE;
                else model_list.delete(pos - 1);
            end
            default: begin
                for (int i = 0; i < len; i++) begin
                    if (model_list[i] == op.value) begin
                        reply.found = plc_pkg::FOUND_W'(i + 1);
                        break;
                    end
                end
            end
        endcase
        reply.length = plc_pkg::LEN_W'(model_list.size());
        return reply;
    endfunction

    function automatic list_op_t make_op(logic [plc_pkg::ACTION_W-1:0] action,
                                         logic [plc_pkg::POS_W-1:0] position,
                                         logic [plc_pkg::VALUE_W-1:0] value);
        list_op_t op;
        op.action   = action;
        op.position = position;
        op.value    = value;
        return op;
    endfunction

    // adds one item at the back of the driver queue
    function automatic void queue_op(list_op_t op);
        pending_ops.insert(pending_ops.size(), op);
    endfunction

    // pool value, an in-range value, or any 31-bit pattern
    function automatic logic [plc_pkg::VALUE_W-1:0] pick_value();
        int dice;
        dice = $urandom_range(3);
        if (dice == 0) return value_pool[$urandom_range(3)];
        if (dice == 3) return plc_pkg::VALUE_W'($urandom);
        return plc_pkg::VALUE_W'(int'($urandom_range(2000000000)) - 1000000000);
    endfunction

    // Well-formed items steered towards a target length, with a little noise.
    // Reads the predicted list, which lags the queue by a couple of items;
    // the odd stale position just becomes another range error.
    function automatic list_op_t pick_random_op(int target);
        list_op_t op;
        int       len;
        int       dice;
        bit       grow;
        len  = model_list.size();
        dice = $urandom_range(99);
        grow = (len < target) ? ($urandom_range(99) < 92) : ($urandom_range(99) < 15);
        op = make_op(plc_pkg::ACT_FIND, plc_pkg::POS_W'($urandom), pick_value());
        if (dice < 5) begin
            op.action = plc_pkg::ACTION_W'($urandom);    // noise: every field random
        end else if (dice < 15) begin
            if (len > 0 && $urandom_range(3) != 0)
                op.value = model_list[$urandom_range(len - 1)];
        end else if (grow) begin
            if ($urandom_range(1) == 0) begin
                op.action = plc_pkg::ACT_APPEND;
            end else begin
                op.action   = plc_pkg::ACT_INSERT;
                op.position = plc_pkg::POS_W'($urandom_range(len + 1, 1));
            end
        end else begin
            op.action   = plc_pkg::ACT_DELETE;
            op.position = (len == 0) ? plc_pkg::POS_W'(1)
                                     : plc_pkg::POS_W'($urandom_range(len, 1));
        end
        return op;
    endfunction

    // keeps the queue short so the generator sees a nearly current list
    task automatic feed_random(int target);
        while (pending_ops.size() >= 2) @(posedge aclk);
        #1;
        queue_op(pick_random_op(target));
    endtask

    // idling: sender 12 / receiver 66, then swapped, then none
    always_comb begin
        if (items_taken < PHASE_ITEMS) begin
            send_idle_pct = 12;
            recv_idle_pct = 66;
        end else if (items_taken < 2 * PHASE_ITEMS) begin
            send_idle_pct = 66;
            recv_idle_pct = 12;
        end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
    end

    // ---------------------------------------------------------------
    // Driver: inputs change on the falling edge. A held item stays until
    // it is taken; a new one is offered only once the last has gone.
    // ---------------------------------------------------------------
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_fire) begin
            if (pending_ops.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                s_tvalid <= 1'b1;
                s_tdata  <= {6'b0, pending_ops.pop_front()};
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin
        m_tready <= aresetn && ($urandom_range(99) >= recv_idle_pct);
    end

    // ---------------------------------------------------------------
    // Monitor: on the rising edge, check a reply against the oldest
    // expectation first, then predict for an item taken at the same edge.
    // ---------------------------------------------------------------
    always @(posedge aclk) begin
        list_reply_t got;
        list_reply_t want;
        got = list_reply_t'(m_tdata[20:0]);
        s_fire <= aresetn && s_tvalid && s_tready;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_replies.size() == 0) begin
                error_count++;
                if (reports < MAX_REPORTS) begin
                    reports++;
                    $display("%0t: reply with none expected: %s %0d found %0d length %0d",
                             $realtime, "status", got.status, $signed(got.found),
                             got.length);
                end
            end else begin
                want = expected_replies.pop_front();
                if (got.status !== want.status || got.found !== want.found ||
                    got.length !== want.length) begin
                    error_count++;
                    if (reports < MAX_REPORTS) begin
                        reports++;
                        $display("%0t: mismatch: expected status %0d found %0d length %0d,",
                                 $realtime, want.status, $signed(want.found),
                                 want.length);
                        $display("    got status %0d found %0d length %0d",
                                 got.status, $signed(got.found), got.length);
                    end
                end
            end
        end
        if (aresetn && s_tvalid && s_tready) begin
            expected_replies.insert(expected_replies.size(),
                                    predict_list_op(list_op_t'(s_tdata[41:0])));
            items_taken++;
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Stimulus: directed corners, then a fill to full with some rejected
    // grows, then a short drift downwards with the normal mix.
    // ---------------------------------------------------------------
    initial begin
        int full_hits;
        int fill_items;
        full_hits  = 0;
        fill_items = 0;

        // empty list: every delete and every insert not at position 1 is out of range
        queue_op(make_op(plc_pkg::ACT_DELETE, 9'd1, 31'd5));
        queue_op(make_op(plc_pkg::ACT_FIND, 9'd0, 31'h0));
        queue_op(make_op(plc_pkg::ACT_INSERT, 9'd2, 31'd9));
        queue_op(make_op(plc_pkg::ACT_INSERT, 9'd0, 31'd9));
        // extremes of the value range and of the 31-bit pattern
        queue_op(make_op(plc_pkg::ACT_INSERT, 9'd1, 31'd1000000000));
        queue_op(make_op(plc_pkg::ACT_APPEND, 9'h1FF, plc_pkg::VALUE_W'(-1000000000)));
        queue_op(make_op(plc_pkg::ACT_APPEND, 9'h0, 31'h7FFF_FFFF));
        queue_op(make_op(plc_pkg::ACT_APPEND, 9'h155, 31'h4000_0000));
        // insert at length + 1 is the tail; a duplicate further up
        queue_op(make_op(plc_pkg::ACT_INSERT, 9'd5, 31'd5));
        queue_op(make_op(plc_pkg::ACT_INSERT, 9'd3, 31'h7FFF_FFFF));
        // first match wins, head match, absent value
        queue_op(make_op(plc_pkg::ACT_FIND, 9'h0AA, 31'h7FFF_FFFF));
        queue_op(make_op(plc_pkg::ACT_FIND, 9'h1FF, 31'd1000000000));
        queue_op(make_op(plc_pkg::ACT_FIND, 9'd3, 31'd12345));
        queue_op(make_op(plc_pkg::ACT_FIND, 9'd0, 31'd5));
        // positions past the end and at the top of the field
        queue_op(make_op(plc_pkg::ACT_DELETE, 9'd7, 31'd0));
        queue_op(make_op(plc_pkg::ACT_DELETE, 9'h1FF, 31'h7FFF_FFFF));
        queue_op(make_op(plc_pkg::ACT_INSERT, 9'h1FF, 31'd3));
        queue_op(make_op(plc_pkg::ACT_INSERT, 9'd8, 31'd3));
        queue_op(make_op(plc_pkg::ACT_DELETE, 9'd0, 31'd0));
        // tail and head deletes
        queue_op(make_op(plc_pkg::ACT_DELETE, 9'd6, 31'd0));
        queue_op(make_op(plc_pkg::ACT_DELETE, 9'd1, 31'h7FFF_FFFF));
        queue_op(make_op(plc_pkg::ACT_FIND, 9'd0, 31'h4000_0000));
        queue_op(make_op(plc_pkg::ACT_FIND, 9'd0, plc_pkg::VALUE_W'(-1000000000)));

        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        // fill until the list has been full for a handful of grows
        while (full_hits < 10 && fill_items < 700) begin
            feed_random(CAPACITY + 1);
            fill_items++;
            if (model_list.size() >= CAPACITY) full_hits++;
        end
        repeat (20) feed_random(0);

        while (pending_ops.size() > 0 || s_tvalid || expected_replies.size() > 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (error_count == 0 && expected_replies.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
